// ----- hw/rtl/i2r_pkg.sv -----
`timescale 1ns / 1ps

package i2r_pkg;

	localparam int unsigned NUM_W    = 12;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned CAP_W    = 8;
	localparam int unsigned CHAR_W   = 7;
	localparam logic [NUM_W-1:0] NUMERAL_MAX = 12'd3999;

	localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;
	localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
	localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
	localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
	localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
	localparam logic [CHAR_W-1:0] CH_I    = 7'h49;

	// Result of one compare/subtract against the table entry at the current position.
	typedef struct packed {
		logic              ge;
		logic [NUM_W-1:0]  diff;
		logic [CHAR_W-1:0] first_ch;
		logic [CHAR_W-1:0] second_ch;
		logic              pair;
	} i2r_step_t;

	function automatic logic [NUM_W-1:0] step_value(input logic [POS_W-1:0] pos);
		logic [NUM_W-1:0] v;
		case (pos)
			4'd0:    v = 12'd1000;
			4'd1:    v = 12'd900;
			4'd2:    v = 12'd500;
			4'd3:    v = 12'd400;
			4'd4:    v = 12'd100;
			4'd5:    v = 12'd90;
			4'd6:    v = 12'd50;
			4'd7:    v = 12'd40;
			4'd8:    v = 12'd10;
			4'd9:    v = 12'd9;
			4'd10:   v = 12'd5;
			4'd11:   v = 12'd4;
			default: v = 12'd1;
		endcase
		return v;
	endfunction

	function automatic logic [CHAR_W-1:0] first_char(input logic [POS_W-1:0] pos);
		logic [CHAR_W-1:0] c;
		case (pos)
			4'd0:    c = CH_M;
			4'd1:    c = CH_C;
			4'd2:    c = CH_D;
			4'd3:    c = CH_C;
			4'd4:    c = CH_C;
			4'd5:    c = CH_X;
			4'd6:    c = CH_L;
			4'd7:    c = CH_X;
			4'd8:    c = CH_X;
			4'd9:    c = CH_I;
			4'd10:   c = CH_V;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	// CH_NONE marks a single-letter entry
	function automatic logic [CHAR_W-1:0] second_char(input logic [POS_W-1:0] pos);
		logic [CHAR_W-1:0] c;
		case (pos)
			4'd1:    c = CH_M;
			4'd3:    c = CH_D;
			4'd5:    c = CH_C;
			4'd7:    c = CH_L;
			4'd9:    c = CH_X;
			4'd11:   c = CH_V;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/integer_to_roman_numeral.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// in        in_valid / in_stall       number[11:0]
// out       out_valid / out_stall     letter[6:0], last_letter, error_flag
// cfg       cfg_wr_en                 cfg_wr_data[7:0] -> buffer capacity
//
// One compare/subtract unit walks the 13-entry table twice per number: a
// counting pass (one subtraction or table advance per step) and an emit
// pass (one letter per cycle while out_stall is low, plus table advances).
// A rejected number loads one error beat. in_stall is high from acceptance
// until the last beat is loaded into the output register; out_stall holds
// the emit pass. Reset clears state and sets capacity to 16.
module integer_to_roman_numeral (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  letter,
	output logic        last_letter,
	output logic        error_flag
);
	import i2r_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EMIT,
		ST_ERR
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  rem_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              pend_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] letter_q;
	logic              last_q;
	logic              err_q;

	i2r_step_t         step;
	logic              slot_free;
	logic              in_take;
	logic              in_bad;
	logic              beat_load;
	logic [LEN_W-1:0]  cnt_next;

	i2r_step_unit u_step (
		.rem  (rem_q),
		.pos  (pos_q),
		.step (step)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign in_take     = in_valid && !in_stall;
	assign in_bad      = (number == '0) || (number > NUMERAL_MAX);
	assign slot_free   = !out_valid_q || !out_stall;
	assign cnt_next    = cnt_q + LEN_W'(1);
	assign beat_load   = slot_free && (((state_q == ST_EMIT) && (pend_q || step.ge))
		|| (state_q == ST_ERR));

	assign out_valid   = out_valid_q;
	assign letter      = letter_q;
	assign last_letter = last_q;
	assign error_flag  = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= 8'd16;
			num_q       <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			letter_q    <= '0;
			last_q      <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			// load a new beat, or drop the current one once taken
			if (beat_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						num_q  <= number;
						rem_q  <= number;
						pos_q  <= '0;
						len_q  <= '0;
						cnt_q  <= '0;
						pend_q <= 1'b0;
						state_q <= in_bad ? ST_ERR : ST_COUNT;
					end
				end
				ST_COUNT: begin
					if (rem_q == '0) begin
						// length known: check it against capacity, then rewind
						rem_q  <= num_q;
						pos_q  <= '0;
						state_q <= ({4'd0, len_q} >= cap_q) ? ST_ERR : ST_EMIT;
					end else if (step.ge) begin
						rem_q <= step.diff;
						len_q <= len_q + (step.pair ? LEN_W'(2) : LEN_W'(1));
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_EMIT: begin
					if (pend_q) begin
						if (slot_free) begin
							letter_q    <= step.second_ch;
							last_q      <= (cnt_next == len_q);
							err_q       <= 1'b0;
							cnt_q       <= cnt_next;
							pend_q      <= 1'b0;
							if (cnt_next == len_q) begin
								state_q <= ST_IDLE;
							end
						end
					end else if (step.ge) begin
						if (slot_free) begin
							letter_q    <= step.first_ch;
							last_q      <= (cnt_next == len_q);
							err_q       <= 1'b0;
							cnt_q       <= cnt_next;
							rem_q       <= step.diff;
							pend_q      <= step.pair;
							if (cnt_next == len_q) begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						letter_q    <= CH_NONE;
						last_q      <= 1'b1;
						err_q       <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/i2r_step_unit.sv -----
`timescale 1ns / 1ps

module i2r_step_unit (
	input  logic [11:0]        rem,
	input  logic [3:0]         pos,
	output i2r_pkg::i2r_step_t step
);
	import i2r_pkg::*;

	logic [NUM_W-1:0] val;

	always_comb begin
		val            = step_value(pos);
		step.ge        = (rem >= val);
		step.diff      = rem - val;
		step.first_ch  = first_char(pos);
		step.second_ch = second_char(pos);
		step.pair      = (step.second_ch != CH_NONE);
	end

endmodule

// ----- verif/tb_integer_to_roman_numeral.sv -----
`timescale 1ns / 1ps

module tb_integer_to_roman_numeral;

	import i2r_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 70;
	localparam int TABLE_ENTRIES = 13;

	typedef struct packed {
		logic [NUM_W-1:0]  number;
		logic [CHAR_W-1:0] letter;
		logic              last;
		logic              err;
	} roman_beat_t;

	typedef struct packed {
		logic [NUM_W-1:0]  value;
		logic [CHAR_W-1:0] lead;
		logic [CHAR_W-1:0] tail;
	} numeral_entry_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [7:0]        cfg_wr_data;
	logic              in_valid;
	logic              in_stall;
	logic [11:0]       number;
	logic              out_valid;
	logic              out_stall;
	logic [6:0]        letter;
	logic              last_letter;
	logic              error_flag;

	roman_beat_t       numeral_due[$];
	logic [CAP_W-1:0]  capacity_shadow;
	int                mismatch_count;
	int                cycle_count;
	bit                idling_on;

	integer_to_roman_numeral i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.number     (number),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter     (letter),
		.last_letter(last_letter),
		.error_flag (error_flag)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= idling_on && ($urandom_range(0, 99) < 25);
	end

	// Greedy table, largest value first; tail is CH_NONE for single letters.
	function automatic numeral_entry_t numeral_entry(input int pos);
		numeral_entry_t e;
		case (pos)
			0:       e = '{12'd1000, CH_M, CH_NONE};
			1:       e = '{12'd900,  CH_C, CH_M};
			2:       e = '{12'd500,  CH_D, CH_NONE};
			3:       e = '{12'd400,  CH_C, CH_D};
			4:       e = '{12'd100,  CH_C, CH_NONE};
			5:       e = '{12'd90,   CH_X, CH_C};
			6:       e = '{12'd50,   CH_L, CH_NONE};
			7:       e = '{12'd40,   CH_X, CH_L};
			8:       e = '{12'd10,   CH_X, CH_NONE};
			9:       e = '{12'd9,    CH_I, CH_X};
			10:      e = '{12'd5,    CH_V, CH_NONE};
			11:      e = '{12'd4,    CH_I, CH_V};
			default: e = '{12'd1,    CH_I, CH_NONE};
		endcase
		return e;
	endfunction

	task automatic predict_numeral(input logic [NUM_W-1:0] num);
		roman_beat_t       b;
		numeral_entry_t    e;
		logic [CHAR_W-1:0] run[$];
		logic [NUM_W-1:0]  rest;
		b.number = num;
		b.letter = CH_NONE;
		b.last   = 1'b1;
		b.err    = 1'b1;
		if (num == '0 || num > NUMERAL_MAX) begin
			numeral_due.push_back(b);
			return;
		end
		rest = num;
		for (int pos = 0; pos < TABLE_ENTRIES; pos++) begin
			e = numeral_entry(pos);
			while (rest >= e.value) begin
				rest = rest - e.value;
				run.push_back(e.lead);
				if (e.tail != CH_NONE)
					run.push_back(e.tail);
			end
		end
		// the numeral plus its terminator must fit the capacity
		if (run.size() >= int'(capacity_shadow)) begin
			numeral_due.push_back(b);
			return;
		end
		foreach (run[i]) begin
			b.letter = run[i];
			b.last   = (i == run.size() - 1);
			b.err    = 1'b0;
			numeral_due.push_back(b);
		end
	endtask

	always @(posedge clk) begin
		roman_beat_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (numeral_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: letter %h last %b err %b",
						letter, last_letter, error_flag);
			end else begin
				exp_b = numeral_due.pop_front();
				if (letter !== exp_b.letter || last_letter !== exp_b.last
						|| error_flag !== exp_b.err) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch %0d: exp %h/%b/%b got %h/%b/%b",
							exp_b.number, exp_b.letter, exp_b.last, exp_b.err,
							letter, last_letter, error_flag);
				end
			end
		end
	end

	task automatic send_number(input logic [NUM_W-1:0] num);
		int gap;
		gap = 0;
		@(negedge clk);
		while (idling_on && $urandom_range(0, 99) < 25)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		number   <= num;
		do
			@(posedge clk);
		while (in_stall);
		predict_numeral(num);
	endtask

	task automatic drain_results();
		while (numeral_due.size() != 0)
			@(posedge clk);
	endtask

	// Drop valid, let the block settle, then write the capacity.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		@(negedge clk);
		in_valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en       <= 1'b1;
		cfg_wr_data     <= cap;
		capacity_shadow  = cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_table_entries();
		logic [NUM_W-1:0] vals[$];
		vals = '{12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90,
			12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd3999, 12'd3888};
		foreach (vals[i])
			send_number(vals[i]);
	endtask

	task automatic test_out_of_range();
		send_number(12'd0);
		send_number(12'd4000);
		send_number(12'd4095);
	endtask

	task automatic test_capacity_limits();
		set_capacity(8'd0);
		send_number(12'd1);
		set_capacity(8'd2);
		send_number(12'd1);
		send_number(12'd2);
		set_capacity(8'd15);
		send_number(12'd3888);
		send_number(12'd3887);
		set_capacity(8'd255);
		send_number(12'd3888);
	endtask

	task automatic test_random_numbers();
		logic [CAP_W-1:0] cap;
		logic [NUM_W-1:0] num;
		int               pick;
		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 3))
				0:       cap = CAP_W'($urandom_range(0, 255));
				1:       cap = CAP_W'($urandom_range(2, 8));
				2:       cap = 8'd255;
				default: cap = CAP_W'($urandom_range(9, 15));
			endcase
			if (phase == 0)
				cap = 8'd16;
			set_capacity(cap);
			// one phase runs with both sides streaming flat out
			idling_on = (phase != 3);
			for (int n = 0; n < 27; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					num = '0;
				else if (pick < 15)
					num = NUM_W'($urandom_range(4000, 4095));
				else if (pick < 30)
					num = NUM_W'($urandom_range(3000, 3999));
				else
					num = NUM_W'($urandom_range(1, 3999));
				send_number(num);
			end
		end
		idling_on = 1'b1;
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		in_valid        = 1'b0;
		number          = '0;
		out_stall       = 1'b0;
		capacity_shadow = 8'd16;
		mismatch_count  = 0;
		cycle_count     = 0;
		idling_on       = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_table_entries();
		test_out_of_range();
		test_capacity_limits();
		test_random_numbers();

		@(negedge clk);
		in_valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && numeral_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
